// ===== src/lbfp_pkg.sv =====
// lbfp_pkg: shared constants and types for the lifetime-aware best-fit placer
// no dependencies; used by lbfp_cmp and the top level
`default_nettype none

package lbfp_pkg;

    localparam int DEF_ENTRIES   = 256;
    localparam int DEF_ADDR_BITS = 32;
    localparam int DEF_STEP_BITS = 16;

    localparam int SIZE_W = 32;
    localparam int OFFS_W = 32;
    localparam int STEP_W = 16;

    // result of one pass of the shared compare unit
    typedef struct packed {
        logic busy;    // lifetime touches the new one and range is non-empty
        logic covers;  // range covers the candidate gap start
        logic above;   // range starts above the candidate gap start
        logic lower;   // start is below the current minimum start
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== src/lbfp_mem.sv =====
// lbfp_mem: placed-buffer table, one write port and one registered read port
// no dependencies
`default_nettype none

module lbfp_mem #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/lbfp_cmp.sv =====
// lbfp_cmp: shared compare unit, one table entry against the current item
// depends on lbfp_pkg
`default_nettype none

module lbfp_cmp
    import lbfp_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int STEP_BITS = DEF_STEP_BITS
) (
    input  wire logic [ADDR_BITS-1:0] ent_start,
    input  wire logic [ADDR_BITS-1:0] ent_end,
    input  wire logic [STEP_BITS-1:0] ent_first,
    input  wire logic [STEP_BITS:0]   ent_lend,
    input  wire logic [STEP_BITS-1:0] item_first,
    input  wire logic [STEP_BITS:0]   item_lend,
    input  wire logic [ADDR_BITS-1:0] gap_start,
    input  wire logic [ADDR_BITS-1:0] min_start,
    output cmp_res_t                  res
);

    always_comb
    begin
        res.busy   = ({1'b0, ent_first} <= item_lend) &&
                     (ent_lend >= {1'b0, item_first}) &&
                     (ent_start < ent_end);
        res.covers = (ent_start <= gap_start) && (ent_end > gap_start);
        res.above  = ent_start > gap_start;
        res.lower  = ent_start < min_start;
    end

endmodule

`default_nettype wire

// ===== src/lifetime_aware_best_fit_placer.sv =====
// lifetime_aware_best_fit_placer: top level, sequencer around table and compare unit
// depends on lbfp_pkg, lbfp_mem, lbfp_cmp
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-----------------------------------------
// in       | in        | in_valid / in_stall | start_plan, alloc_size, life_first,
//          |           |                     | life_last
// out      | out       | out_valid/out_stall | offset, table_full, addr_overflow
//
// the end of each busy entry is a candidate gap start and is checked against the whole
// table through the single read port
// the table itself needs no clearing after reset, only the count is reset
// in_stall is high while a word is being placed; a result waiting at the output
// does not block the next word, only the delivery of its result
`default_nettype none

module lifetime_aware_best_fit_placer
    import lbfp_pkg::*;
#(
    parameter int ENTRIES   = DEF_ENTRIES,
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int STEP_BITS = DEF_STEP_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              start_plan,
    input  wire logic [SIZE_W-1:0] alloc_size,
    input  wire logic [STEP_W-1:0] life_first,
    input  wire logic [STEP_W-1:0] life_last,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [OFFS_W-1:0]      offset,
    output logic                   table_full,
    output logic                   addr_overflow
);

    localparam int AB = ADDR_BITS;
    localparam int SB = STEP_BITS;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = $clog2(ENTRIES);
    localparam int XW = (AB > SIZE_W) ? AB : SIZE_W;
    localparam int MW = (SB > STEP_W) ? SB : STEP_W;
    localparam int OW = (XW > OFFS_W) ? XW : OFFS_W;
    localparam int EW = 2 * AB + 2 * SB + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_OUT_RD, S_OUT_EV, S_INNER, S_GAP, S_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            pv_reg, pv_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SB-1:0]   first_reg, first_next;
    logic [SB:0]     lend_reg, lend_next;
    logic [AB-1:0]   e_reg, e_next;
    logic [AB-1:0]   maxe_reg, maxe_next;
    logic [AB-1:0]   mins_reg, mins_next;
    logic            cov_reg, cov_next;
    logic            above_reg, above_next;
    logic            any_reg, any_next;
    logic            found_reg, found_next;
    logic [AB-1:0]   best_reg, best_next;
    logic [AB-1:0]   boff_reg, boff_next;
    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic            full_reg, full_next;
    logic            ovf_reg, ovf_next;
    logic            out_valid_reg, out_valid_next;

    logic [MW-1:0]   first_ext, last_ext;
    logic [IW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data, wr_data;
    logic            wr_en;
    logic [AB-1:0]   ent_start, ent_end;
    logic [SB-1:0]   ent_first;
    logic [SB:0]     ent_lend;
    cmp_res_t        cres;
    logic [AB-1:0]   gap;
    logic            gap_fits;
    logic [AB-1:0]   off_c;
    logic [XW:0]     sum_c;
    logic            full_c, ovf_c;
    logic [OW-1:0]   off_wide;
    logic            out_free;

    assign first_ext = MW'(life_first);
    assign last_ext  = MW'(life_last);

    assign ent_start = rd_data[EW-1 -: AB];
    assign ent_end   = rd_data[EW-1-AB -: AB];
    assign ent_first = rd_data[SB + SB : SB + 1];
    assign ent_lend  = rd_data[SB:0];

    assign rd_addr = (state_reg == S_OUT_RD) ? i_reg[IW-1:0] : j_reg[IW-1:0];

    lbfp_mem #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lbfp_cmp #(
        .ADDR_BITS (AB),
        .STEP_BITS (SB)
    ) u_cmp (
        .ent_start  (ent_start),
        .ent_end    (ent_end),
        .ent_first  (ent_first),
        .ent_lend   (ent_lend),
        .item_first (first_reg),
        .item_lend  (lend_reg),
        .gap_start  (e_reg),
        .min_start  (mins_reg),
        .res        (cres)
    );

    // gap arithmetic and final placement
    assign gap      = mins_reg - e_reg;
    assign gap_fits = XW'(gap) >= XW'(size_reg);
    assign off_c    = any_reg ? (found_reg ? boff_reg : maxe_reg) : '0;
    assign sum_c    = (XW + 1)'(off_c) + (XW + 1)'(size_reg);
    assign ovf_c    = sum_c[XW:AB] != '0;
    assign full_c   = cnt_reg >= CW'(ENTRIES);
    assign off_wide = OW'(off_c);
    assign out_free = !out_valid_reg || !out_stall;
    assign wr_en    = (state_reg == S_FIN) && out_free && !full_c && !ovf_c;
    assign wr_data  = {off_c, sum_c[AB-1:0], first_reg, lend_reg};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pv_next        = pv_reg;
        size_next      = size_reg;
        first_next     = first_reg;
        lend_next      = lend_reg;
        e_next         = e_reg;
        maxe_next      = maxe_reg;
        mins_next      = mins_reg;
        cov_next       = cov_reg;
        above_next     = above_reg;
        any_next       = any_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        boff_next      = boff_reg;
        offset_next    = offset_reg;
        full_next      = full_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (start_plan)
                    begin
                        cnt_next = '0;
                    end
                    size_next  = alloc_size;
                    first_next = first_ext[SB-1:0];
                    lend_next  = (SB + 1)'(last_ext[SB-1:0]) + (SB + 1)'(1);
                    i_next     = '0;
                    any_next   = 1'b0;
                    found_next = 1'b0;
                    maxe_next  = '0;
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = (i_reg >= cnt_reg) ? S_FIN : S_OUT_EV;
            end
            S_OUT_EV:
            begin
                i_next = i_reg + CW'(1);
                if (cres.busy)
                begin
                    // this entry's end is a candidate gap start
                    e_next     = ent_end;
                    any_next   = 1'b1;
                    maxe_next  = (ent_end > maxe_reg) ? ent_end : maxe_reg;
                    j_next     = '0;
                    pv_next    = 1'b0;
                    cov_next   = 1'b0;
                    above_next = 1'b0;
                    mins_next  = '1;
                    state_next = S_INNER;
                end
                else
                begin
                    state_next = S_OUT_RD;
                end
            end
            S_INNER:
            begin
                pv_next = j_reg < cnt_reg;
                if (j_reg < cnt_reg)
                begin
                    j_next = j_reg + CW'(1);
                end
                if (pv_reg && cres.busy)
                begin
                    if (cres.covers)
                    begin
                        cov_next = 1'b1;
                    end
                    if (cres.above && (cres.lower || !above_reg))
                    begin
                        mins_next  = ent_start;
                        above_next = 1'b1;
                    end
                end
                if (!(j_reg < cnt_reg) && !pv_reg)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                if (!cov_reg && above_reg && gap_fits &&
                    (!found_reg || gap < best_reg ||
                     (gap == best_reg && e_reg < boff_reg)))
                begin
                    found_next = 1'b1;
                    best_next  = gap;
                    boff_next  = e_reg;
                end
                state_next = S_OUT_RD;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    offset_next    = off_wide[OFFS_W-1:0];
                    full_next      = full_c;
                    ovf_next       = ovf_c;
                    out_valid_next = 1'b1;
                    if (!full_c && !ovf_c)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            pv_reg        <= 1'b0;
            any_reg       <= 1'b0;
            found_reg     <= 1'b0;
            cov_reg       <= 1'b0;
            above_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pv_reg        <= pv_next;
            any_reg       <= any_next;
            found_reg     <= found_next;
            cov_reg       <= cov_next;
            above_reg     <= above_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg   <= size_next;
        first_reg  <= first_next;
        lend_reg   <= lend_next;
        e_reg      <= e_next;
        maxe_reg   <= maxe_next;
        mins_reg   <= mins_next;
        best_reg   <= best_next;
        boff_reg   <= boff_next;
        offset_reg <= offset_next;
        full_reg   <= full_next;
        ovf_reg    <= ovf_next;
    end

    assign in_stall      = state_reg != S_IDLE;
    assign out_valid     = out_valid_reg;
    assign offset        = offset_reg;
    assign table_full    = full_reg;
    assign addr_overflow = ovf_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count above table depth");

    a_write_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < CW'(ENTRIES)) && !ovf_c)
        else $error("table write without room or with overflow");

    a_flag_blocks_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free && (full_c || ovf_c)) |=>
            cnt_reg == $past(cnt_reg))
        else $error("flagged word changed the entry count");

    a_inner_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INNER) |-> (j_reg <= cnt_reg))
        else $error("inner scan index past the stored entries");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for lifetime_aware_best_fit_placer: random and directed placements,
// checked against a behavioral scoreboard; depends on lbfp_pkg and the placer rtl
`timescale 1ns / 100ps

module testbench;
    import lbfp_pkg::*;

    localparam int SLOTS = DEF_ENTRIES;
    localparam int IDLE_LIMIT = 400000;

    typedef struct {
        logic [OFFS_W-1:0] offset;
        logic              full;
        logic              ovf;
    } placement_t;

    class placement_scoreboard;
        logic [63:0] arena_lo [SLOTS];
        logic [63:0] arena_hi [SLOTS];
        logic [63:0] live_first [SLOTS];
        logic [63:0] live_end [SLOTS];
        int          used;
        placement_t  pending [$];
        int          errors;

        function new();
            used = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // predict the placement of one accepted word
        function void note_word(logic sp, logic [SIZE_W-1:0] sz,
                                logic [STEP_W-1:0] lf, logic [STEP_W-1:0] ll);
            logic [63:0] bs [$];
            logic [63:0] be [$];
            logic [63:0] first, lend, off, cur, best, gap, fin;
            logic        found;
            int          k;
            placement_t  p;
            if (sp) used = 0;
            first = {48'd0, lf};
            lend = {48'd0, ll} + 64'd1;
            for (int i = 0; i < used; i++) begin
                if (live_first[i] <= lend && live_end[i] >= first
                        && arena_lo[i] < arena_hi[i]) begin
                    k = 0;
                    while (k < bs.size() && bs[k] <= arena_lo[i]) k++;
                    bs.insert(k, arena_lo[i]);
                    be.insert(k, arena_hi[i]);
                end
            end
            off = 0;
            if (bs.size() != 0) begin
                cur = be[0];
                best = 0;
                found = 0;
                for (int i = 1; i < bs.size(); i++) begin
                    if (bs[i] <= cur) begin
                        if (be[i] > cur) cur = be[i];
                    end else begin
                        gap = bs[i] - cur;
                        if (gap >= {32'd0, sz} && (!found || gap < best)) begin
                            found = 1;
                            best = gap;
                            off = cur;
                        end
                        cur = be[i];
                    end
                end
                if (!found) off = cur;
            end
            fin = off + {32'd0, sz};
            p.full = used >= SLOTS;
            p.ovf = fin > 64'hFFFF_FFFF;
            p.offset = off[31:0];
            if (!p.full && !p.ovf) begin
                arena_lo[used] = off;
                arena_hi[used] = fin;
                live_first[used] = first;
                live_end[used] = lend;
                used++;
            end
            pending.insert(pending.size(), p);
        endfunction

        task check_result(logic [OFFS_W-1:0] o, logic f, logic v);
            placement_t p;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result offset %h", o));
            end else begin
                p = pending.pop_front();
                if (o !== p.offset)
                    report($sformatf("offset %h, want %h", o, p.offset));
                if (f !== p.full)
                    report($sformatf("table_full %b, want %b", f, p.full));
                if (v !== p.ovf)
                    report($sformatf("addr_overflow %b, want %b", v, p.ovf));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              start_plan;
    logic [SIZE_W-1:0] alloc_size;
    logic [STEP_W-1:0] life_first;
    logic [STEP_W-1:0] life_last;
    logic              out_valid;
    logic              out_stall;
    logic [OFFS_W-1:0] offset;
    logic              table_full;
    logic              addr_overflow;

    placement_scoreboard sb;
    logic calm;
    logic hold_req;
    int   idle_cycles;

    lifetime_aware_best_fit_placer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_plan(start_plan), .alloc_size(alloc_size),
        .life_first(life_first), .life_last(life_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .offset(offset), .table_full(table_full), .addr_overflow(addr_overflow)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // drive one word, with a random gap before it unless calm is set, and wait until accepted
    task send_word(logic sp, logic [SIZE_W-1:0] sz,
                   logic [STEP_W-1:0] lf, logic [STEP_W-1:0] ll);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 20) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        start_plan = sp;
        alloc_size = sz;
        life_first = lf;
        life_last = ll;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(sp, sz, lf, ll);
    endtask

    task go_idle();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task wait_drained();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // random word: mostly small sizes and lifetimes clustered in a window, some extreme ones
    task send_random(int base);
        logic [SIZE_W-1:0] sz;
        logic [STEP_W-1:0] lf, ll;
        int r;
        r = $urandom_range(99);
        if (r < 5) sz = $urandom;
        else if (r < 10) sz = 32'hFFFF_FFFF - $urandom_range(64);
        else if (r < 15) sz = 0;
        else sz = $urandom_range(64, 1);
        lf = 16'(base + $urandom_range(15));
        ll = 16'(lf + $urandom_range(8));
        r = $urandom_range(99);
        if (r < 8) begin
            lf = 16'($urandom);
            ll = 16'($urandom);
        end else if (r < 12) begin
            ll = 16'(lf - $urandom_range(4, 1));
        end
        send_word($urandom_range(11) == 0, sz, lf, ll);
    endtask

    // receiver: random stalls, one long counted hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                for (int k = 0; k < 3000; k++) begin
                    out_stall = 1'b1;
                    @(negedge clk);
                end
                hold_req = 1'b0;
            end
            out_stall = (!calm && $urandom_range(99) < 20);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(offset, table_full, addr_overflow);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("lifetime_aware_best_fit_placer regression: fail");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        calm = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_plan = 1'b0;
        alloc_size = '0;
        life_first = '0;
        life_last = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, zero size, reversed lifetime, overflow
        send_word(1'b1, 32'd1, 16'd0, 16'd0);
        send_word(1'b0, 32'd0, 16'd0, 16'd3);
        send_word(1'b0, 32'd16, 16'd0, 16'd1);
        send_word(1'b0, 32'd16, 16'd0, 16'd9);
        send_word(1'b0, 32'd8, 16'd0, 16'd1);
        send_word(1'b0, 32'd16, 16'd5, 16'd9);
        send_word(1'b0, 32'd4, 16'd9, 16'd2);
        send_word(1'b0, 32'd7, 16'hFFFF, 16'hFFFF);
        send_word(1'b0, 32'd3, 16'hFFFF, 16'd0);
        send_word(1'b1, 32'hFFFF_FFFF, 16'd100, 16'd200);
        send_word(1'b0, 32'd1, 16'd150, 16'd160);
        send_word(1'b0, 32'hFFFF_FFFF, 16'd300, 16'd300);
        send_word(1'b0, 32'hAAAA_5555, 16'h5555, 16'hAAAA);
        send_word(1'b0, 32'h5555_AAAA, 16'hAAAA, 16'h5555);

        // a run of disjoint lifetimes, then an overflowing word
        send_word(1'b1, 32'd1, 16'd0, 16'd0);
        for (int i = 1; i < 16; i++)
            send_word(1'b0, 32'd1, 16'(4 * i), 16'(4 * i));
        send_word(1'b0, 32'hFFFF_FFFF, 16'd0, 16'd0);

        // sender pauses until all results are in
        go_idle();
        wait_drained();

        calm = 1'b1;
        for (int i = 0; i < 20; i++) send_random(32);
        calm = 1'b0;
        hold_req = 1'b1;
        send_word(1'b1, 32'd5, 16'd10, 16'd20);
        for (int i = 0; i < 48; i++) send_random(($urandom_range(3) == 0) ? 64 : 0);
        go_idle();

        wait_drained();
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lifetime_aware_best_fit_placer regression: pass");
        else
            $display("lifetime_aware_best_fit_placer regression: fail");
        $finish;
    end

endmodule
